// ----- rtl/rlpd_pkg.sv -----
package rlpd_pkg;

  localparam int COLOR_W = 24;
  localparam int TICK_W  = 15;
  localparam int CNT_W   = 9;
  localparam int CFG_W   = 15;
  localparam int REG_W   = 3;

  // request codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SHOW  = 2'd3;

  // register indexes
  localparam logic [REG_W-1:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_ONE_HIGH    = 3'd1;
  localparam logic [REG_W-1:0] REG_ONE_LOW     = 3'd2;
  localparam logic [REG_W-1:0] REG_ZERO_HIGH   = 3'd3;
  localparam logic [REG_W-1:0] REG_ZERO_LOW    = 3'd4;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_PIXEL_COUNT = 9'd1;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH    = 15'd8;
  localparam logic [TICK_W-1:0] RST_ONE_LOW     = 15'd5;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH   = 15'd4;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 15'd8;

  // last bit position of a pixel in send order
  localparam logic [4:0] BIT_LAST = 5'd23;

  typedef struct packed {
    logic accept;
    logic write;
    logic clear;
    logic start;
    logic tick;
    logic load_first;
    logic busy;
  } rlpd_cmd_t;

  typedef struct packed {
    logic count_nz;
    logic frame_end;
  } rlpd_sts_t;

  // Colour bit at send position k: green, red, blue, MSB first.
  function automatic logic send_bit(input logic [COLOR_W-1:0] color, input logic [4:0] k);
    logic [COLOR_W-1:0] grb;
    logic [4:0]         pos;
    grb = {color[15:8], color[23:16], color[7:0]};
    pos = BIT_LAST - k;
    return grb[pos];
  endfunction

endpackage

// ----- rtl/rlpd_in_if.sv -----
interface rlpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  pixel_index;
  logic [23:0] pixel_color;

  modport source (output valid, output op, output pixel_index, output pixel_color,
                  input ready);
  modport sink (input valid, input op, input pixel_index, input pixel_color,
                output ready);
endinterface

// ----- rtl/rlpd_out_if.sv -----
interface rlpd_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;

  modport source (output valid, output line_level, output busy_res, input ready);
  modport sink (input valid, input line_level, input busy_res, output ready);
endinterface

// ----- rtl/rlpd_ram.sv -----
module rlpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rlpd_ctrl.sv -----
module rlpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  input  logic                out_ready,
  input  rlpd_pkg::rlpd_sts_t sts,
  output logic                in_ready,
  output logic                out_valid,
  output rlpd_pkg::rlpd_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SEND = 3'b100
  } rlpd_state_t;

  rlpd_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        idle;
  logic        send;

  assign idle     = (state_r == ST_IDLE);
  assign send     = (state_r == ST_SEND);
  // stall during the pixel zero fetch, otherwise take a request whenever the
  // result slot is free or drains this cycle
  assign in_ready = (state_r != ST_LOAD) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.write      = accept && idle && (in_op == rlpd_pkg::OP_WRITE);
    cmd.clear      = accept && idle && (in_op == rlpd_pkg::OP_CLEAR);
    cmd.start      = accept && idle && (in_op == rlpd_pkg::OP_SHOW) && sts.count_nz;
    cmd.tick       = accept && send && (in_op == rlpd_pkg::OP_TICK);
    cmd.load_first = (state_r == ST_LOAD);
    cmd.busy       = send || cmd.start;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (cmd.tick && sts.frame_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/rlpd_dp.sv -----
module rlpd_dp #(
  parameter int MAX_PIXELS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlpd_pkg::REG_W-1:0]         cfg_index,
  input  logic [rlpd_pkg::CFG_W-1:0]         cfg_data,
  input  logic [7:0]                         pixel_index,
  input  logic [rlpd_pkg::COLOR_W-1:0]       pixel_color,
  input  rlpd_pkg::rlpd_cmd_t                cmd,
  output rlpd_pkg::rlpd_sts_t                sts,
  output logic                               out_level,
  output logic                               out_busy
);

  localparam int PW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int EW = (CW > rlpd_pkg::CNT_W) ? CW : rlpd_pkg::CNT_W;
  localparam int TW = rlpd_pkg::TICK_W;

  logic [rlpd_pkg::CNT_W-1:0]   pixel_count_r;
  logic [TW-1:0]                one_high_r, one_low_r, zero_high_r, zero_low_r;

  logic [PW-1:0]                ptr_r, ptr_nxt;
  logic [4:0]                   bit_r, bit_nxt;
  logic                         high_r, high_nxt;
  logic [TW-1:0]                tick_r, tick_nxt;
  logic [rlpd_pkg::COLOR_W-1:0] cur_color_r, cur_color_nxt;
  logic                         rd_vld_r;
  logic [MAX_PIXELS-1:0]        valid_r;
  logic                         out_level_r, out_busy_r;

  logic [EW-1:0]                eff_count;
  logic                         wr_ok;
  logic [PW-1:0]                wr_addr;
  logic [PW-1:0]                rd_addr;
  logic                         rd_in_range;
  logic [rlpd_pkg::COLOR_W-1:0] ram_rdata;
  logic [rlpd_pkg::COLOR_W-1:0] color_rd;
  logic                         cur_bit;
  logic [TW-1:0]                phase_len;
  logic [TW-1:0]                len_eff;
  logic [TW:0]                  tick_inc;
  logic                         phase_end;
  logic                         last_bit;
  logic                         last_pixel;

  // counts beyond the store size act as the store size
  assign eff_count = (EW'(pixel_count_r) > EW'(MAX_PIXELS)) ? EW'(MAX_PIXELS)
                                                           : EW'(pixel_count_r);
  assign wr_ok     = EW'(pixel_index) < eff_count;
  assign wr_addr   = PW'(pixel_index);

  // fetch pixel zero on a frame start, otherwise keep the next pixel ready
  assign rd_addr     = cmd.start ? '0 : ptr_r + PW'(1);
  assign rd_in_range = EW'(rd_addr) < EW'(MAX_PIXELS);

  rlpd_ram #(
    .WIDTH (rlpd_pkg::COLOR_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write && wr_ok),
    .waddr (wr_addr),
    .wdata (pixel_color),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // entries not written since the last clear read as black
  assign color_rd = rd_vld_r ? ram_rdata : '0;

  assign cur_bit = rlpd_pkg::send_bit(cur_color_r, bit_r);

  always_comb begin
    case ({high_r, cur_bit})
      2'b11:   phase_len = one_high_r;
      2'b10:   phase_len = zero_high_r;
      2'b01:   phase_len = one_low_r;
      default: phase_len = zero_low_r;
    endcase
  end

  assign len_eff    = (phase_len == '0) ? TW'(1) : phase_len;
  assign tick_inc   = {1'b0, tick_r} + (TW+1)'(1);
  assign phase_end  = tick_inc >= {1'b0, len_eff};
  assign last_bit   = (bit_r == rlpd_pkg::BIT_LAST);
  assign last_pixel = (EW'(ptr_r) + EW'(1)) >= eff_count;

  assign sts.count_nz  = (eff_count != '0);
  assign sts.frame_end = !high_r && phase_end && last_bit && last_pixel;

  always_comb begin
    ptr_nxt       = ptr_r;
    bit_nxt       = bit_r;
    high_nxt      = high_r;
    tick_nxt      = tick_r;
    cur_color_nxt = cur_color_r;
    if (cmd.start) begin
      ptr_nxt  = '0;
      bit_nxt  = '0;
      high_nxt = 1'b1;
      tick_nxt = '0;
    end
    if (cmd.load_first) begin
      cur_color_nxt = color_rd;
    end
    if (cmd.tick) begin
      if (!phase_end) begin
        tick_nxt = tick_inc[TW-1:0];
      end else begin
        tick_nxt = '0;
        if (high_r) begin
          high_nxt = 1'b0;
        end else begin
          high_nxt = 1'b1;
          if (last_bit) begin
            bit_nxt = '0;
            if (last_pixel) begin
              high_nxt = 1'b0;
              ptr_nxt  = '0;
            end else begin
              ptr_nxt       = ptr_r + PW'(1);
              cur_color_nxt = color_rd;
            end
          end else begin
            bit_nxt = bit_r + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= rlpd_pkg::RST_PIXEL_COUNT;
      one_high_r    <= rlpd_pkg::RST_ONE_HIGH;
      one_low_r     <= rlpd_pkg::RST_ONE_LOW;
      zero_high_r   <= rlpd_pkg::RST_ZERO_HIGH;
      zero_low_r    <= rlpd_pkg::RST_ZERO_LOW;
      ptr_r         <= '0;
      bit_r         <= '0;
      high_r        <= 1'b0;
      tick_r        <= '0;
      valid_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rlpd_pkg::REG_PIXEL_COUNT: pixel_count_r <= cfg_data[rlpd_pkg::CNT_W-1:0];
          rlpd_pkg::REG_ONE_HIGH:    one_high_r    <= cfg_data;
          rlpd_pkg::REG_ONE_LOW:     one_low_r     <= cfg_data;
          rlpd_pkg::REG_ZERO_HIGH:   zero_high_r   <= cfg_data;
          rlpd_pkg::REG_ZERO_LOW:    zero_low_r    <= cfg_data;
          default: ;
        endcase
      end
      ptr_r  <= ptr_nxt;
      bit_r  <= bit_nxt;
      high_r <= high_nxt;
      tick_r <= tick_nxt;
      if (cmd.clear) begin
        valid_r <= '0;
      end else if (cmd.write && wr_ok) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_color_r <= cur_color_nxt;
    rd_vld_r    <= rd_in_range && valid_r[rd_addr];
    if (cmd.accept) begin
      out_level_r <= cmd.tick && high_r;
      out_busy_r  <= cmd.busy;
    end
  end

  assign out_level = out_level_r;
  assign out_busy  = out_busy_r;

endmodule

// ----- rtl/rgb_led_chain_pulse_driver_core.sv -----
// Channel   | Dir | Handshake     | Payload
// ----------+-----+---------------+------------------------------------------
// in_chan   | in  | valid / ready | op[1:0], pixel_index[7:0], pixel_color[23:0]
// out_chan  | out | valid / ready | line_level, busy_res
// cfg_*     | in  | cfg_we only   | cfg_index[2:0], cfg_data[14:0]
//
// Every request yields exactly one result, registered in the cycle after it is taken.
// Requests are taken one per cycle unless stalled; a show that starts a frame
// stalls in_chan for the registered read of pixel zero from the store RAM.
// The result register frees itself in the cycle it is taken, so a stalled
// out_chan only holds in_chan while a result is waiting.
// Reset (rst_n low, synchronous) loads register defaults and marks the whole
// pixel store as black at once through per-entry valid flags; no clear pass.
module rgb_led_chain_pulse_driver_core #(
  parameter int MAX_PIXELS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rlpd_in_if.sink                    in_chan,
  rlpd_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [rlpd_pkg::REG_W-1:0] cfg_index,
  input  logic [rlpd_pkg::CFG_W-1:0] cfg_data
);

  rlpd_pkg::rlpd_cmd_t cmd;
  rlpd_pkg::rlpd_sts_t sts;

  // Controller: request decode, frame sequencing, result handshake.
  rlpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  // Datapath: registers, pixel store, bit and tick counters, result payload.
  rlpd_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_index (in_chan.pixel_index),
    .pixel_color (in_chan.pixel_color),
    .cmd         (cmd),
    .sts         (sts),
    .out_level   (out_chan.line_level),
    .out_busy    (out_chan.busy_res)
  );

  // Hold off the next request while pixel zero is fetched.
  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_chan.ready)
    else $error("request taken during pixel zero fetch");

  // Drive the line high only inside a frame.
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.line_level) |-> out_chan.busy_res)
    else $error("line high outside a frame");

  // Store changes and ticks never coincide.
  a_tick_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> !(cmd.write || cmd.clear || cmd.start))
    else $error("tick decoded together with a store or show request");

  // The closing tick of a frame is low and still reported busy.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && sts.frame_end) |=>
      (out_chan.valid && out_chan.busy_res && !out_chan.line_level))
    else $error("bad result for the last tick of a frame");

endmodule
